// ===== sv/dpog_pkg.sv =====
// Shared types and constants for the depth-pixel to occupancy-grid core.
// Used by the controller, the datapath and the divider; depends on nothing.
package dpog_pkg;

   // input operation codes
   localparam logic [1:0] OP_POSE  = 2'd0;
   localparam logic [1:0] OP_PIXEL = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // result kinds
   localparam logic KIND_POINT = 1'b0;
   localparam logic KIND_CELL  = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CFG_WIDTH   = 3'd0;
   localparam logic [2:0] CFG_HEIGHT  = 3'd1;
   localparam logic [2:0] CFG_MAX_RNG = 3'd2;
   localparam logic [2:0] CFG_MIN_HGT = 3'd3;
   localparam logic [2:0] CFG_MAX_HGT = 3'd4;
   localparam logic [2:0] CFG_CELL    = 3'd5;

   localparam logic [12:0] RST_WIDTH   = 13'd512;
   localparam logic [12:0] RST_HEIGHT  = 13'd512;
   localparam logic [15:0] RST_MAX_RNG = 16'd5000;
   localparam logic [23:0] RST_MIN_HGT = 24'd500;
   localparam logic [23:0] RST_MAX_HGT = 24'd1500;
   localparam logic [9:0]  RST_CELL    = 10'd50;

   localparam logic [15:0] MIN_DEPTH_MM = 16'd100;
   localparam logic [6:0]  OBSTACLE     = 7'd100;

   // pixel subsampling step
   localparam int PIXEL_STEP = 2;
   localparam int STEP_RECIP = ((1 << 24) + PIXEL_STEP - 1) / PIXEL_STEP;

   // shared divider: signed dividend, unsigned divisor
   localparam int DIV_W  = 40;
   localparam int DEN_W  = 13;
   localparam int DCNT_W = $clog2(DIV_W);

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_POSE_MUL,
      ACT_POSE_FIN,
      ACT_B_MUL,
      ACT_ACC_MUL,
      ACT_DIV_WORLD,
      ACT_TAKE_WORLD,
      ACT_DIV_CELL,
      ACT_TAKE_CELL,
      ACT_SET_RD,
      ACT_MAP_RD,
      ACT_MAP_WR,
      ACT_EMIT_PT,
      ACT_EMIT_RD,
      ACT_CLEAR
   } act_type;

   typedef struct packed {
      act_type    act;
      logic [3:0] idx;
      logic [1:0] k;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       pix_ok;
      logic       z_ok;
      logic       div_done;
      logic       clear_last;
      logic       rsp_busy;
   } status_type;

   // true when c is a multiple of PIXEL_STEP (reciprocal multiply, exact for 12 bits)
   function automatic logic step_aligned(input logic [11:0] c);
      logic [35:0] p;
      logic [11:0] q;
      logic [15:0] back;
      p    = 36'(c) * 36'(STEP_RECIP);
      q    = p[35:24];
      back = 16'(q) * 16'(PIXEL_STEP);
      return back[11:0] == c;
   endfunction

endpackage

// ===== sv/dpog_divider.sv =====
// Shared multi-cycle divider: signed dividend, unsigned divisor, floor or truncation.
// Restoring, one quotient bit per cycle. Depends on dpog_pkg.
module dpog_divider import dpog_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    floor_mode,
   input  logic signed [DIV_W-1:0] numer,
   input  logic [DEN_W-1:0]        denom,
   output logic                    done,
   output logic signed [DIV_W-1:0] quot
);

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_PREP = 3'b010,
      D_RUN  = 3'b100
   } dstate_type;

   dstate_type              state_ff, state_in;
   logic [DCNT_W-1:0]       cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic signed [DIV_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic                    flr_ff, flr_in;
   logic                    neg_ff, neg_in;
   logic [DIV_W-1:0]        q_ff, q_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [DEN_W:0]          rem_sh;
   logic [DEN_W:0]          rem_sub;
   logic                    take;

   assign rem_sh  = {rem_ff, q_ff[DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign take    = rem_sh >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      num_in   = num_ff;
      den_in   = den_ff;
      flr_in   = flr_ff;
      neg_in   = neg_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               num_in   = numer;
               den_in   = denom;
               flr_in   = floor_mode;
               state_in = D_PREP;
            end
         end
         D_PREP: begin
            // floor of a negative value: divide |n| + d - 1 and negate
            neg_in = num_ff[DIV_W-1];
            if (num_ff[DIV_W-1]) begin
               q_in = DIV_W'(-num_ff) +
                      (flr_ff ? DIV_W'(den_ff) - DIV_W'(1) : DIV_W'(0));
            end else begin
               q_in = DIV_W'(num_ff);
            end
            rem_in   = '0;
            cnt_in   = '0;
            state_in = D_RUN;
         end
         D_RUN: begin
            rem_in = take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            q_in   = {q_ff[DIV_W-2:0], take};
            cnt_in = cnt_ff + DCNT_W'(1);
            if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      flr_ff <= flr_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

// ===== sv/dpog_datapath.sv =====
// Datapath: config registers, pose store, multiply/accumulate, divider, obstacle map
// and the result register. Driven by commands from dpog_ctrl; uses dpog_pkg, dpog_divider.
module dpog_datapath import dpog_pkg::*; #(
   parameter int MAP_SIDE = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   input  logic [1:0]         req_operation,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [23:0] req_cam_x_mm,
   input  logic signed [23:0] req_cam_y_mm,
   input  logic signed [23:0] req_cam_z_mm,
   input  logic [11:0]        req_col,
   input  logic [11:0]        req_row,
   input  logic [15:0]        req_depth_mm,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic signed [23:0] rsp_point_x_mm,
   output logic signed [23:0] rsp_point_y_mm,
   output logic signed [23:0] rsp_point_z_mm,
   output logic [6:0]         rsp_cell_value
);

   localparam int IDX_W = $clog2(MAP_SIDE);
   localparam int HALF  = MAP_SIDE / 2;

   // configuration
   logic [12:0]        width_ff, height_ff;
   logic [15:0]        max_rng_ff;
   logic signed [23:0] min_hgt_ff, max_hgt_ff;
   logic [9:0]         cell_ff;

   // latched transaction
   logic [1:0]         op_ff;
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [23:0] cx_ff, cy_ff, cz_ff;
   logic [11:0]        col_ff, row_ff;
   logic [15:0]        depth_ff;

   // pose
   logic signed [31:0] prod_ff [9];
   logic signed [17:0] rot_ff [9];
   logic signed [23:0] pos_ff [3];
   logic               pose_valid_ff;

   // pixel
   logic signed [30:0] b_ff [3];
   logic signed [50:0] acc_ff, acc_in;
   logic signed [DIV_W-1:0] world_ff [3];
   logic [IDX_W-1:0]   map_col_ff, map_row_ff;
   logic               col_ok_ff, row_ok_ff;

   // map
   logic [MAP_SIDE-1:0] map_mem [MAP_SIDE];
   logic [MAP_SIDE-1:0] row_q_ff;
   logic [IDX_W-1:0]    clr_row_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [MAP_SIDE-1:0] mem_wdata;

   // result
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic signed [23:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [6:0]         rsp_cell_ff;

   logic signed [15:0] pa, pb;
   logic signed [31:0] pprod;
   logic signed [13:0] bfac;
   logic signed [30:0] bprod;
   logic signed [17:0] rsel;
   logic signed [48:0] mprod;
   logic [3:0]         rix;
   logic signed [50:0] wsum, wshift;
   logic [9:0]         cell_eff;
   logic signed [DIV_W-1:0] cell_num;
   logic               div_start, div_done;
   logic               div_floor;
   logic signed [DIV_W-1:0] div_numer, div_quot;
   logic [DEN_W-1:0]   div_denom;
   logic               pix_ok;
   logic               q_in_map;

   function automatic logic signed [17:0] q14_entry(input logic signed [34:0] v);
      logic signed [34:0] t;
      t = (v + 35'sd8192) >>> 14;
      if (t > 35'sd131071) begin
         return 18'sd131071;
      end else if (t < -35'sd131072) begin
         return -18'sd131072;
      end
      return t[17:0];
   endfunction

   function automatic logic signed [23:0] out24(input logic signed [DIV_W-1:0] v);
      if (v > DIV_W'(24'sh7fffff)) begin
         return 24'sh7fffff;
      end else if (v < -(DIV_W'(24'sh7fffff)) - DIV_W'(1)) begin
         return -24'sh7fffff - 24'sd1;
      end
      return v[23:0];
   endfunction

   function automatic logic signed [34:0] x35(input logic signed [31:0] v);
      return 35'(v);
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RST_WIDTH;
         height_ff  <= RST_HEIGHT;
         max_rng_ff <= RST_MAX_RNG;
         min_hgt_ff <= RST_MIN_HGT;
         max_hgt_ff <= RST_MAX_HGT;
         cell_ff    <= RST_CELL;
      end else if (csr_wr_en) begin
         case (csr_index)
            CFG_WIDTH:   width_ff   <= csr_wdata[12:0];
            CFG_HEIGHT:  height_ff  <= csr_wdata[12:0];
            CFG_MAX_RNG: max_rng_ff <= csr_wdata[15:0];
            CFG_MIN_HGT: min_hgt_ff <= csr_wdata;
            CFG_MAX_HGT: max_hgt_ff <= csr_wdata;
            CFG_CELL:    cell_ff    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // quaternion product pairs
   always_comb begin
      case (cmd.idx)
         4'd0: begin pa = qx_ff; pb = qx_ff; end
         4'd1: begin pa = qy_ff; pb = qy_ff; end
         4'd2: begin pa = qz_ff; pb = qz_ff; end
         4'd3: begin pa = qx_ff; pb = qy_ff; end
         4'd4: begin pa = qw_ff; pb = qz_ff; end
         4'd5: begin pa = qx_ff; pb = qz_ff; end
         4'd6: begin pa = qw_ff; pb = qy_ff; end
         4'd7: begin pa = qy_ff; pb = qz_ff; end
         default: begin pa = qw_ff; pb = qx_ff; end
      endcase
      pprod = pa * pb;
   end

   // body-frame ray: d*W, d*(W-2u), d*(H-2v)
   always_comb begin
      case (cmd.idx[1:0])
         2'd0:    bfac = $signed({1'b0, width_ff});
         2'd1:    bfac = $signed({1'b0, width_ff}) - $signed({1'b0, col_ff, 1'b0});
         default: bfac = $signed({1'b0, height_ff}) - $signed({1'b0, row_ff, 1'b0});
      endcase
      bprod = $signed({1'b0, depth_ff}) * bfac;
   end

   assign rix    = 4'({2'b00, cmd.k} * 4'd3) + cmd.idx;
   assign rsel   = rot_ff[rix];
   assign mprod  = rsel * b_ff[cmd.idx[1:0]];
   assign acc_in = (cmd.idx == 4'd0 ? 51'sd0 : acc_ff) + 51'(mprod);

   // floor((S + D/2) / D) with D = W * 2^14: shift out 2^14, then divide by W
   assign wsum     = acc_ff + 51'($signed({1'b0, width_ff, 13'b0}));
   assign wshift   = wsum >>> 14;
   assign cell_eff = (cell_ff == 10'd0) ? 10'd1 : cell_ff;
   assign cell_num = world_ff[cmd.k] + DIV_W'(DIV_W'(cell_eff) * DIV_W'(HALF));

   assign div_start = (cmd.act == ACT_DIV_WORLD) || (cmd.act == ACT_DIV_CELL);
   assign div_floor = (cmd.act == ACT_DIV_WORLD);
   assign div_numer = (cmd.act == ACT_DIV_WORLD) ? wshift[DIV_W-1:0] : cell_num;
   assign div_denom = (cmd.act == ACT_DIV_WORLD) ? width_ff : DEN_W'(cell_eff);

   dpog_divider u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .floor_mode (div_floor),
      .numer      (div_numer),
      .denom      (div_denom),
      .done       (div_done),
      .quot       (div_quot)
   );

   assign q_in_map = !div_quot[DIV_W-1] && ($unsigned(div_quot) < DIV_W'(MAP_SIDE));

   assign pix_ok = pose_valid_ff && (width_ff != 13'd0) &&
                   step_aligned(col_ff) && step_aligned(row_ff) &&
                   ({1'b0, col_ff} < width_ff) && ({1'b0, row_ff} < height_ff) &&
                   (depth_ff > MIN_DEPTH_MM) && (depth_ff <= max_rng_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_valid_ff <= 1'b0;
      end else if (cmd.act == ACT_POSE_FIN) begin
         pose_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.act)
         ACT_LOAD: begin
            op_ff    <= req_operation;
            qw_ff    <= req_quat_w;
            qx_ff    <= req_quat_x;
            qy_ff    <= req_quat_y;
            qz_ff    <= req_quat_z;
            cx_ff    <= req_cam_x_mm;
            cy_ff    <= req_cam_y_mm;
            cz_ff    <= req_cam_z_mm;
            col_ff   <= req_col;
            row_ff   <= req_row;
            depth_ff <= req_depth_mm;
         end
         ACT_POSE_MUL: prod_ff[cmd.idx] <= pprod;
         ACT_POSE_FIN: begin
            rot_ff[0] <= q14_entry((35'sd1 <<< 28) - 35'sd2 * (x35(prod_ff[1]) + x35(prod_ff[2])));
            rot_ff[1] <= q14_entry(35'sd2 * (x35(prod_ff[3]) - x35(prod_ff[4])));
            rot_ff[2] <= q14_entry(35'sd2 * (x35(prod_ff[5]) + x35(prod_ff[6])));
            rot_ff[3] <= q14_entry(35'sd2 * (x35(prod_ff[3]) + x35(prod_ff[4])));
            rot_ff[4] <= q14_entry((35'sd1 <<< 28) - 35'sd2 * (x35(prod_ff[0]) + x35(prod_ff[2])));
            rot_ff[5] <= q14_entry(35'sd2 * (x35(prod_ff[7]) - x35(prod_ff[8])));
            rot_ff[6] <= q14_entry(35'sd2 * (x35(prod_ff[5]) - x35(prod_ff[6])));
            rot_ff[7] <= q14_entry(35'sd2 * (x35(prod_ff[7]) + x35(prod_ff[8])));
            rot_ff[8] <= q14_entry((35'sd1 <<< 28) - 35'sd2 * (x35(prod_ff[0]) + x35(prod_ff[1])));
            pos_ff[0] <= cx_ff;
            pos_ff[1] <= cy_ff;
            pos_ff[2] <= cz_ff;
         end
         ACT_B_MUL:      b_ff[cmd.idx[1:0]] <= bprod;
         ACT_ACC_MUL:    acc_ff <= acc_in;
         ACT_TAKE_WORLD: world_ff[cmd.k] <= div_quot + DIV_W'(pos_ff[cmd.k]);
         ACT_TAKE_CELL: begin
            if (cmd.k == 2'd0) begin
               map_col_ff <= div_quot[IDX_W-1:0];
               col_ok_ff  <= q_in_map;
            end else begin
               map_row_ff <= div_quot[IDX_W-1:0];
               row_ok_ff  <= q_in_map;
            end
         end
         ACT_SET_RD: begin
            map_col_ff <= col_ff[IDX_W-1:0];
            map_row_ff <= row_ff[IDX_W-1:0];
            col_ok_ff  <= {1'b0, col_ff} < 13'(MAP_SIDE);
            row_ok_ff  <= {1'b0, row_ff} < 13'(MAP_SIDE);
         end
         default: ;
      endcase
   end

   // map: one row per word, read-modify-write to set a cell
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = map_row_ff;
      mem_wdata = row_q_ff | (MAP_SIDE'(1) << map_col_ff);
      if (cmd.act == ACT_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_row_ff;
         mem_wdata = '0;
      end else if (cmd.act == ACT_MAP_WR) begin
         mem_we = col_ok_ff && row_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act == ACT_MAP_RD) begin
         row_q_ff <= map_mem[map_row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
      end else if (cmd.act == ACT_CLEAR) begin
         clr_row_ff <= clr_row_ff + IDX_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.act == ACT_EMIT_PT || cmd.act == ACT_EMIT_RD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act == ACT_EMIT_PT) begin
         rsp_kind_ff <= KIND_POINT;
         rsp_x_ff    <= out24(world_ff[0]);
         rsp_y_ff    <= out24(world_ff[1]);
         rsp_z_ff    <= out24(world_ff[2]);
         rsp_cell_ff <= 7'd0;
      end else if (cmd.act == ACT_EMIT_RD) begin
         rsp_kind_ff <= KIND_CELL;
         rsp_x_ff    <= '0;
         rsp_y_ff    <= '0;
         rsp_z_ff    <= '0;
         rsp_cell_ff <= (col_ok_ff && row_ok_ff && row_q_ff[map_col_ff]) ? OBSTACLE : 7'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_point_x_mm = rsp_x_ff;
   assign rsp_point_y_mm = rsp_y_ff;
   assign rsp_point_z_mm = rsp_z_ff;
   assign rsp_cell_value = rsp_cell_ff;

   assign status.op         = op_ff;
   assign status.pix_ok     = pix_ok;
   assign status.z_ok       = (world_ff[2] > DIV_W'(min_hgt_ff)) &&
                              (world_ff[2] < DIV_W'(max_hgt_ff));
   assign status.div_done   = div_done;
   assign status.clear_last = (clr_row_ff == IDX_W'(MAP_SIDE - 1));
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

endmodule

// ===== sv/dpog_ctrl.sv =====
// Controller: sequences pose, pixel and map-read transactions and the map clear.
// Issues cmd_type commands to dpog_datapath; uses dpog_pkg.
module dpog_ctrl import dpog_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [16:0] {
      S_CLEAR    = 17'b00000000000000001,
      S_IDLE     = 17'b00000000000000010,
      S_DECODE   = 17'b00000000000000100,
      S_POSE_MUL = 17'b00000000000001000,
      S_POSE_FIN = 17'b00000000000010000,
      S_B_MUL    = 17'b00000000000100000,
      S_ACC      = 17'b00000000001000000,
      S_DIV_W    = 17'b00000000010000000,
      S_WAIT_W   = 17'b00000000100000000,
      S_ZCHK     = 17'b00000001000000000,
      S_DIV_C    = 17'b00000010000000000,
      S_WAIT_C   = 17'b00000100000000000,
      S_MAP_RD   = 17'b00001000000000000,
      S_MAP_WR   = 17'b00010000000000000,
      S_EMIT_PT  = 17'b00100000000000000,
      S_RD_ADDR  = 17'b01000000000000000,
      S_EMIT_RD  = 17'b10000000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [1:0] k_ff, k_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      cmd.act  = ACT_NONE;
      cmd.idx  = cnt_ff;
      cmd.k    = k_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.act = ACT_CLEAR;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.act  = ACT_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.act = ACT_SET_RD;
            cnt_in  = 4'd0;
            k_in    = 2'd0;
            case (status.op)
               OP_POSE:  state_in = S_POSE_MUL;
               OP_PIXEL: state_in = status.pix_ok ? S_B_MUL : S_IDLE;
               OP_READ:  state_in = S_RD_ADDR;
               default:  state_in = S_IDLE;
            endcase
         end
         S_POSE_MUL: begin
            cmd.act = ACT_POSE_MUL;
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               state_in = S_POSE_FIN;
            end
         end
         S_POSE_FIN: begin
            cmd.act  = ACT_POSE_FIN;
            state_in = S_IDLE;
         end
         S_B_MUL: begin
            cmd.act = ACT_B_MUL;
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) begin
               cnt_in   = 4'd0;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.act = ACT_ACC_MUL;
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) begin
               cnt_in   = 4'd0;
               state_in = S_DIV_W;
            end
         end
         S_DIV_W: begin
            cmd.act  = ACT_DIV_WORLD;
            state_in = S_WAIT_W;
         end
         S_WAIT_W: begin
            if (status.div_done) begin
               cmd.act = ACT_TAKE_WORLD;
               if (k_ff == 2'd2) begin
                  state_in = S_ZCHK;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_ACC;
               end
            end
         end
         S_ZCHK: begin
            k_in     = 2'd0;
            state_in = status.z_ok ? S_DIV_C : S_IDLE;
         end
         S_DIV_C: begin
            cmd.act  = ACT_DIV_CELL;
            state_in = S_WAIT_C;
         end
         S_WAIT_C: begin
            if (status.div_done) begin
               cmd.act = ACT_TAKE_CELL;
               if (k_ff == 2'd1) begin
                  state_in = S_MAP_RD;
               end else begin
                  k_in     = 2'd1;
                  state_in = S_DIV_C;
               end
            end
         end
         S_MAP_RD: begin
            cmd.act  = ACT_MAP_RD;
            state_in = S_MAP_WR;
         end
         S_MAP_WR: begin
            cmd.act  = ACT_MAP_WR;
            state_in = S_EMIT_PT;
         end
         S_EMIT_PT: begin
            if (!status.rsp_busy) begin
               cmd.act  = ACT_EMIT_PT;
               state_in = S_IDLE;
            end
         end
         S_RD_ADDR: begin
            cmd.act  = ACT_MAP_RD;
            state_in = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            if (!status.rsp_busy) begin
               cmd.act  = ACT_EMIT_RD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= 4'd0;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
      end
   end

endmodule

// ===== sv/depth_pixel_to_occupancy_grid_core.sv =====
// Depth pixel to occupancy grid core. One transaction at a time, accept to accept. An
// obstacle pixel runs three ray products, per world axis three multiply-accumulates and
// a division, the height test, two cell divisions, a map read and write and the emit,
// which waits for a free result register; divisions use the shared divider (one quotient
// bit per cycle). Reset is synchronous; afterward a clear pass wipes the map, one row per
// cycle, before the first transaction is taken.
module depth_pixel_to_occupancy_grid_core import dpog_pkg::*; #(
   parameter int MAP_SIDE = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [23:0] req_cam_x_mm,
   input  logic signed [23:0] req_cam_y_mm,
   input  logic signed [23:0] req_cam_z_mm,
   input  logic [11:0]        req_col,
   input  logic [11:0]        req_row,
   input  logic [15:0]        req_depth_mm,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic signed [23:0] rsp_point_x_mm,
   output logic signed [23:0] rsp_point_y_mm,
   output logic signed [23:0] rsp_point_z_mm,
   output logic [6:0]         rsp_cell_value
);

   cmd_type    cmd;
   status_type status;

   dpog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dpog_datapath #(
      .MAP_SIDE (MAP_SIDE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_operation  (req_operation),
      .req_quat_w     (req_quat_w),
      .req_quat_x     (req_quat_x),
      .req_quat_y     (req_quat_y),
      .req_quat_z     (req_quat_z),
      .req_cam_x_mm   (req_cam_x_mm),
      .req_cam_y_mm   (req_cam_y_mm),
      .req_cam_z_mm   (req_cam_z_mm),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_depth_mm   (req_depth_mm),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_point_x_mm (rsp_point_x_mm),
      .rsp_point_y_mm (rsp_point_y_mm),
      .rsp_point_z_mm (rsp_point_z_mm),
      .rsp_cell_value (rsp_cell_value)
   );

endmodule

// ===== tb/sv/depth_pixel_to_occupancy_grid_core_tb.sv =====
// Self-checking bench for depth_pixel_to_occupancy_grid_core: directed and random
// pose, pixel and map-read traffic checked against an in-bench occupancy predictor.
// Depends on dpog_pkg and the core RTL only.
module depth_pixel_to_occupancy_grid_core_tb;
   import dpog_pkg::*;

   localparam int SIDE      = 512;
   localparam int STALL_MAX = 2000;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] qw, qx, qy, qz;
      logic signed [23:0] px, py, pz;
      logic [11:0]        col, row;
      logic [15:0]        depth;
   } req_t;

   typedef struct packed {
      logic               kind;
      logic signed [23:0] x, y, z;
      logic [6:0]         cval;
   } rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   req_t req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_t rsp;

   always #2 clock = ~clock;

   depth_pixel_to_occupancy_grid_core #(.MAP_SIDE(SIDE)) dut (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_operation(req.op),
      .req_quat_w(req.qw), .req_quat_x(req.qx), .req_quat_y(req.qy), .req_quat_z(req.qz),
      .req_cam_x_mm(req.px), .req_cam_y_mm(req.py), .req_cam_z_mm(req.pz),
      .req_col(req.col), .req_row(req.row), .req_depth_mm(req.depth),
      .rsp_valid, .rsp_ready, .rsp_kind(rsp.kind),
      .rsp_point_x_mm(rsp.x), .rsp_point_y_mm(rsp.y), .rsp_point_z_mm(rsp.z),
      .rsp_cell_value(rsp.cval)
   );

   // predictor state
   longint img_w, img_h, max_rng, min_hgt, max_hgt, cell_mm;
   longint rot[9];
   longint cam_pos[3];
   bit has_pose;
   bit occupied[SIDE*SIDE];

   rsp_t expected_rsps[$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit stress = 1'b0;

   function automatic longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint rot_q14(longint q28);
      return clamp(fdiv(q28 + 8192, 16384), -131072, 131071);
   endfunction

   function automatic void predict_occupancy(req_t r);
      longint w, x, y, z, one, d, bx, by, bz, den, s, cs, ix, iy;
      longint wc[3];
      rsp_t e;
      e = '0;
      case (r.op)
         OP_POSE: begin
            w = r.qw; x = r.qx; y = r.qy; z = r.qz; one = 64'd1 << 28;
            rot[0] = rot_q14(one - 2*(y*y + z*z));
            rot[1] = rot_q14(2*(x*y - w*z));
            rot[2] = rot_q14(2*(x*z + w*y));
            rot[3] = rot_q14(2*(x*y + w*z));
            rot[4] = rot_q14(one - 2*(x*x + z*z));
            rot[5] = rot_q14(2*(y*z - w*x));
            rot[6] = rot_q14(2*(x*z - w*y));
            rot[7] = rot_q14(2*(y*z + w*x));
            rot[8] = rot_q14(one - 2*(x*x + y*y));
            cam_pos[0] = r.px; cam_pos[1] = r.py; cam_pos[2] = r.pz;
            has_pose = 1'b1;
         end
         OP_PIXEL: begin
            if (!has_pose || img_w == 0) return;
            if (r.col % PIXEL_STEP != 0 || r.row % PIXEL_STEP != 0) return;
            if (r.col >= img_w || r.row >= img_h) return;
            d = r.depth;
            if (d <= MIN_DEPTH_MM || d > max_rng) return;
            bx = d * img_w;
            by = -(2*longint'(r.col) - img_w) * d;
            bz = -(2*longint'(r.row) - img_h) * d;
            den = img_w * 16384;
            for (int k = 0; k < 3; k++) begin
               s = rot[3*k]*bx + rot[3*k+1]*by + rot[3*k+2]*bz;
               wc[k] = fdiv(s + den/2, den) + cam_pos[k];
            end
            if (!(wc[2] > min_hgt && wc[2] < max_hgt)) return;
            cs = cell_mm == 0 ? 1 : cell_mm;
            ix = (wc[0] + (SIDE/2)*cs) / cs;
            iy = (wc[1] + (SIDE/2)*cs) / cs;
            if (ix >= 0 && ix < SIDE && iy >= 0 && iy < SIDE) occupied[iy*SIDE + ix] = 1'b1;
            e.kind = KIND_POINT;
            e.x = 24'(clamp(wc[0], -8388608, 8388607));
            e.y = 24'(clamp(wc[1], -8388608, 8388607));
            e.z = 24'(clamp(wc[2], -8388608, 8388607));
            expected_rsps.push_back(e);
         end
         OP_READ: begin
            e.kind = KIND_CELL;
            if (r.col < SIDE && r.row < SIDE && occupied[r.row*SIDE + r.col]) e.cval = OBSTACLE;
            expected_rsps.push_back(e);
         end
         default: ;
      endcase
   endfunction

   function automatic int short_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
   endfunction

   // receiver: random backpressure, plus a long hold-off on request
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (1500) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = stress ? short_gap() : 0;
         rsp_ready <= (gap == 0);
         if (gap > 0) begin
            repeat (gap - 1) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected result: actual %p", $time, rsp);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp !== e) begin
               $display("%0t result mismatch: expected %p actual %p", $time, e, rsp);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 40000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // valid stays up across back-to-back transactions; it drops only for a gap or a drain
   task automatic send_item(req_t r);
      int gap;
      gap = stress ? short_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_occupancy(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CFG_WIDTH:   img_w = val[12:0];
         CFG_HEIGHT:  img_h = val[12:0];
         CFG_MAX_RNG: max_rng = val[15:0];
         CFG_MIN_HGT: min_hgt = $signed(val);
         CFG_MAX_HGT: max_hgt = $signed(val);
         CFG_CELL:    cell_mm = val[9:0];
         default: ;
      endcase
   endtask

   function automatic req_t pose_item(int q);
      req_t r;
      r = '0;
      r.op = OP_POSE;
      r.qw = 16384;
      r.pz = 1000;
      case (q)
         1: begin r.qw = 11585; r.qz = 11585; end
         2: begin r.qw = 16384; r.qx = 16384; r.qy = -16384; r.qz = 16384; end
         3: begin r.qw = -16384; r.px = 24'h7FFFFF; r.py = 24'h800000; end
         4: begin
            r.qw = 16'($urandom_range(0, 32768) - 16384);
            r.qx = 16'($urandom_range(0, 32768) - 16384);
            r.qy = 16'($urandom_range(0, 32768) - 16384);
            r.qz = 16'($urandom_range(0, 32768) - 16384);
            r.px = 24'($urandom); r.py = 24'($urandom); r.pz = 24'($urandom);
         end
         5: begin
            r.qw = 16'(16384 - $urandom_range(0, 800));
            r.qz = 16'($urandom_range(0, 4000) - 2000);
            r.qx = 16'($urandom_range(0, 600) - 300);
            r.qy = 16'($urandom_range(0, 600) - 300);
            r.px = 24'($urandom_range(0, 8000) - 4000);
            r.py = 24'($urandom_range(0, 8000) - 4000);
            r.pz = 24'($urandom_range(0, 1200));
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_t pixel_item(int col, int row, int depth);
      req_t r;
      r = '0;
      r.op = OP_PIXEL; r.col = 12'(col); r.row = 12'(row); r.depth = 16'(depth);
      return r;
   endfunction

   function automatic req_t read_item(int col, int row);
      req_t r;
      r = '0;
      r.op = OP_READ; r.col = 12'(col); r.row = 12'(row);
      return r;
   endfunction

   // mostly valid even pixels of the configured image, some noise
   function automatic req_t random_pixel();
      req_t r;
      r = pixel_item(2*$urandom_range(0, (img_h > 1 ? img_w/2 : 1)),
                     2*$urandom_range(0, img_h/2), $urandom_range(150, max_rng + 1));
      if ($urandom_range(0, 9) == 0) begin
         r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
         r.op = OP_PIXEL;
      end
      if (r.col >= img_w) r.col = 0;
      return r;
   endfunction

   task automatic test_no_pose();
      send_item(pixel_item(100, 100, 1000));
      send_item(read_item(0, 0));
      send_item(read_item(SIDE - 1, SIDE - 1));
      drain();
   endtask

   task automatic test_directed();
      send_item(pose_item(0));
      send_item(pixel_item(256, 0, 1000));
      send_item(pixel_item(256, 0, 1000));
      send_item(pixel_item(256, 100, 101));
      send_item(pixel_item(256, 100, 100));
      send_item(pixel_item(256, 100, 5000));
      send_item(pixel_item(256, 100, 5001));
      send_item(pixel_item(257, 100, 1000));
      send_item(pixel_item(256, 101, 1000));
      send_item(pixel_item(512, 0, 1000));
      send_item(pixel_item(0, 510, 4000));
      send_item(pixel_item(4094, 4094, 16'hFFFF));
      send_item(read_item(276, 256));
      send_item(read_item(4095, 4095));
      send_item(read_item(SIDE, 0));
      send_item(pose_item(1));
      send_item(pixel_item(0, 0, 3000));
      send_item(pose_item(2));
      send_item(pixel_item(10, 20, 2000));
      send_item(pose_item(3));
      send_item(pixel_item(0, 0, 5000));
      send_item(req_t'({OP_READ + 2'd1, 176'h0}));
      drain();
   endtask

   task automatic test_config_extremes();
      write_reg(CFG_WIDTH, 0);
      send_item(pose_item(0));
      send_item(pixel_item(0, 0, 1000));
      drain();
      write_reg(CFG_WIDTH, 2);
      write_reg(CFG_HEIGHT, 2);
      write_reg(CFG_MAX_RNG, 16'hFFFF);
      write_reg(CFG_MIN_HGT, 24'h800000);
      write_reg(CFG_MAX_HGT, 24'h7FFFFF);
      write_reg(CFG_CELL, 0);
      send_item(pixel_item(0, 0, 65535));
      send_item(pose_item(3));
      send_item(pixel_item(0, 0, 65535));
      drain();
      write_reg(CFG_WIDTH, 4096);
      write_reg(CFG_HEIGHT, 4096);
      write_reg(CFG_CELL, 1000);
      write_reg(CFG_MAX_RNG, 0);
      send_item(pixel_item(4094, 4094, 200));
      drain();
      write_reg(CFG_MAX_RNG, 5000);
      write_reg(CFG_MIN_HGT, 24'hFFF000);
      write_reg(CFG_MAX_HGT, 4000);
      send_item(pose_item(0));
      send_item(pixel_item(4094, 4094, 5000));
      send_item(pixel_item(0, 0, 101));
      drain();
   endtask

   task automatic test_random(int items);
      int w, h;
      int choice;
      req_t r;
      for (int phase = 0; phase < 4; phase++) begin
         w = 2 + 2*$urandom_range(0, 300); h = 2 + 2*$urandom_range(0, 300);
         write_reg(CFG_WIDTH, w);
         write_reg(CFG_HEIGHT, h);
         write_reg(CFG_MAX_RNG, $urandom_range(500, 8000));
         write_reg(CFG_MIN_HGT, -24'($urandom_range(0, 2000)));
         write_reg(CFG_MAX_HGT, $urandom_range(500, 3000));
         write_reg(CFG_CELL, $urandom_range(1, 120));
         send_item(pose_item(5));
         for (int i = 0; i < items/4; i++) begin
            if (phase == 1 && i == 20) hold_rsp = 1'b1;
            choice = $urandom_range(0, 99);
            if (choice < 4) r = pose_item($urandom_range(0, 9) == 0 ? 4 : 5);
            else if (choice < 70) r = random_pixel();
            else if (choice < 97) begin
               r = read_item($urandom_range(200, 312), $urandom_range(200, 312));
               if ($urandom_range(0, 9) == 0) begin
                  r.col = 12'($urandom); r.row = 12'($urandom);
               end
            end else begin
               r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
               r.op = 2'd3;
            end
            send_item(r);
         end
         drain();
      end
   endtask

   initial begin
      img_w = RST_WIDTH; img_h = RST_HEIGHT; max_rng = RST_MAX_RNG;
      min_hgt = $signed(RST_MIN_HGT); max_hgt = $signed(RST_MAX_HGT); cell_mm = RST_CELL;
      has_pose = 1'b0;
      foreach (rot[i]) rot[i] = 0;
      foreach (cam_pos[i]) cam_pos[i] = 0;
      foreach (occupied[i]) occupied[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_no_pose();
      test_directed();
      stress = 1'b1;
      test_config_extremes();
      test_random(1800);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
